/* rtl/core/pfra_pkg.sv */
// ----------------------------------------------------------------------------
// pfra_pkg
// Shared types and constants for the PI force reference generator: register
// indexes, fixed-point widths and the configuration register bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package pfra_pkg;

    // Field widths
    localparam int FORCE_W  = 32;  // signed Q16.16 force
    localparam int GAIN_W   = 24;  // unsigned Q8.16 gain
    localparam int DT_W     = 24;  // unsigned Q0.24 seconds
    localparam int LIMIT_W  = 31;  // unsigned Q15.16 integrator clamp
    localparam int CONTACT_W = 4;
    localparam int CFG_IDX_W = 3;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRATOR_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MIN       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MAX       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_FORCE    = 3'd5;

    // Register reset values
    localparam logic signed [FORCE_W-1:0] OUTPUT_MIN_RST = 32'sh8000_0000;
    localparam logic signed [FORCE_W-1:0] OUTPUT_MAX_RST = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [GAIN_W-1:0]          prop_gain;
        logic [GAIN_W-1:0]          integral_gain;
        logic [LIMIT_W-1:0]         integrator_limit;
        logic signed [FORCE_W-1:0]  output_min;
        logic signed [FORCE_W-1:0]  output_max;
        logic signed [FORCE_W-1:0]  default_force;
    } pfra_cfg_t;

endpackage

`default_nettype wire

/* rtl/core/pi_force_reference_antiwindup.sv */
// ----------------------------------------------------------------------------
// pi_force_reference_antiwindup
// Per-contact PI force reference with feedforward and conditional
// integration anti-windup, built around one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on item_valid/item_ready and carry a contact index, a
//   measurement-valid flag, desired and measured force and a time step.
//   Each item gives exactly one result on result_valid/result_ready.
//   The user must write registers through cfg_we/cfg_index/cfg_data only while idle; the block does not enforce this.
// Sequence:
//   A normal item makes four passes through the shared 32x24 multiplier
//   (kp*|err|, ki*dt, and the two halves of |err|*ki*dt) plus sum, clamp
//   and anti-windup steps before result_valid. Rejected indexes and
//   invalid measurements skip these steps and go straight to the done
//   state. item_ready is high only while the sequencer is idle, so one
//   item is in work at a time.
// Reset:
//   Clears all integrator entries, loads register defaults, drops
//   result_valid. A stalled receiver holds the result register; the next
//   item may be accepted meanwhile and finishes once the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module pi_force_reference_antiwindup
    import pfra_pkg::*;
#(
    parameter int NUM_CONTACTS = 8
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // Configuration
    input  wire logic                       cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [FORCE_W-1:0]         cfg_data,
    // Item channel
    input  wire logic                       item_valid,
    output logic                            item_ready,
    input  wire logic [CONTACT_W-1:0]       contact,
    input  wire logic                       measure_ok,
    input  wire logic signed [FORCE_W-1:0]  desired_force,
    input  wire logic signed [FORCE_W-1:0]  measured_force,
    input  wire logic [DT_W-1:0]            time_step,
    // Result channel
    output logic                            result_valid,
    input  wire logic                       result_ready,
    output logic signed [FORCE_W-1:0]       reference_force,
    output logic                            index_rejected
);

    localparam int IDX_W = (NUM_CONTACTS > 1) ? $clog2(NUM_CONTACTS) : 1;
    localparam logic [CONTACT_W:0] NUM_LIMIT = (CONTACT_W + 1)'(NUM_CONTACTS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_P,
        S_KD,
        S_LO,
        S_HI,
        S_SUM,
        S_INT,
        S_WIND,
        S_DONE
    } state_t;

    state_t state_reg;

    // Configuration registers
    pfra_cfg_t cfg_reg;

    // Datapath registers
    logic [IDX_W-1:0]          idx_reg;
    logic                      zero_reg;
    logic                      rej_reg;
    logic                      neg_reg;
    logic [MUL_A_W-1:0]        mag_reg;
    logic [DT_W-1:0]           dt_reg;
    logic signed [FORCE_W-1:0] des_reg;
    logic signed [FORCE_W-1:0] iprev_reg;
    logic signed [40:0]        p_reg;
    logic signed [41:0]        pd_reg;
    logic signed [42:0]        pip_reg;
    logic [MUL_B_W-1:0]        kdhi_reg;
    logic [31:0]               lo_reg;
    logic [40:0]               q_reg;
    logic signed [FORCE_W-1:0] inext_reg;
    logic signed [42:0]        sel_reg;

    logic accept;
    logic out_free;
    logic in_range;

    // Shared multiplier
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] prod;

    pfra_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // Integrator store
    logic                      st_we;
    logic signed [FORCE_W-1:0] st_wdata;
    logic signed [FORCE_W-1:0] st_rdata;
    logic [IDX_W-1:0]          st_widx;
    logic                      wind;

    pfra_store #(
        .DEPTH (NUM_CONTACTS),
        .IDX_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (st_we),
        .wr_idx  (st_widx),
        .wr_data (st_wdata),
        .rd_idx  (idx_reg),
        .rd_data (st_rdata)
    );

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;
    assign out_free   = !result_valid || result_ready;
    assign in_range   = {1'b0, contact} < NUM_LIMIT;

    // Select multiplier operands per step
    always_comb
    begin
        mul_a = mag_reg;
        mul_b = cfg_reg.prop_gain;
        unique case (state_reg)
            S_KD:
            begin
                mul_a = MUL_A_W'(dt_reg);
                mul_b = cfg_reg.integral_gain;
            end
            S_LO:    mul_b = prod[MUL_B_W-1:0];
            S_HI:    mul_b = kdhi_reg;
            default: mul_b = cfg_reg.prop_gain;
        endcase
    end

    // Substitute default force and form error magnitude at acceptance
    logic signed [FORCE_W-1:0] des_in;
    logic signed [32:0]        err_in;
    logic signed [32:0]        err_neg;

    always_comb
    begin
        des_in  = (desired_force <= 0) ? cfg_reg.default_force : desired_force;
        err_in  = 33'(des_in) - 33'(measured_force);
        err_neg = -err_in;
    end

    // Integrator step and clamp
    logic signed [41:0] sq;
    logic signed [42:0] isum;
    logic signed [42:0] lim_pos;
    logic signed [42:0] lim_neg;
    logic signed [42:0] inext_c;

    always_comb
    begin
        sq      = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
        isum    = 43'(iprev_reg) + 43'(sq);
        lim_pos = $signed({12'b0, cfg_reg.integrator_limit});
        lim_neg = -lim_pos;
        inext_c = isum;
        if (inext_c < lim_neg)
        begin
            inext_c = lim_neg;
        end
        if (inext_c > lim_pos)
        begin
            inext_c = lim_pos;
        end
    end

    // Provisional output and anti-windup decision
    logic signed [42:0] raw;

    always_comb
    begin
        raw  = 43'(pd_reg) + 43'(inext_reg);
        wind = (raw > 43'(cfg_reg.output_max) && inext_reg > iprev_reg) ||
               (raw < 43'(cfg_reg.output_min) && inext_reg < iprev_reg);
    end

    // Store writes: clear on invalid measurement, update unless winding up
    always_comb
    begin
        st_we    = 1'b0;
        st_widx  = idx_reg;
        st_wdata = inext_reg;
        if (accept && in_range && !measure_ok)
        begin
            st_we    = 1'b1;
            st_widx  = contact[IDX_W-1:0];
            st_wdata = '0;
        end
        else if (state_reg == S_WIND && !wind)
        begin
            st_we = 1'b1;
        end
    end

    // Final output clamp, lower bound first
    logic signed [42:0]        ref_c;
    logic signed [FORCE_W-1:0] ref_out;

    always_comb
    begin
        ref_c = sel_reg;
        if (ref_c < 43'(cfg_reg.output_min))
        begin
            ref_c = 43'(cfg_reg.output_min);
        end
        if (ref_c > 43'(cfg_reg.output_max))
        begin
            ref_c = 43'(cfg_reg.output_max);
        end
        ref_out = zero_reg ? '0 : ref_c[FORCE_W-1:0];
    end

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain        <= '0;
            cfg_reg.integral_gain    <= '0;
            cfg_reg.integrator_limit <= '0;
            cfg_reg.output_min       <= OUTPUT_MIN_RST;
            cfg_reg.output_max       <= OUTPUT_MAX_RST;
            cfg_reg.default_force    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PROP_GAIN:        cfg_reg.prop_gain <= cfg_data[GAIN_W-1:0];
                CFG_INTEGRAL_GAIN:    cfg_reg.integral_gain <= cfg_data[GAIN_W-1:0];
                CFG_INTEGRATOR_LIMIT: cfg_reg.integrator_limit <= cfg_data[LIMIT_W-1:0];
                CFG_OUTPUT_MIN:       cfg_reg.output_min <= $signed(cfg_data);
                CFG_OUTPUT_MAX:       cfg_reg.output_max <= $signed(cfg_data);
                CFG_DEFAULT_FORCE:    cfg_reg.default_force <= $signed(cfg_data);
                default:              ;
            endcase
        end
    end

    // Sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            result_valid    <= 1'b0;
            reference_force <= '0;
            index_rejected  <= 1'b0;
        end
        else
        begin
            // Load a finished item, or drop the one just taken
            if (state_reg == S_DONE && out_free)
            begin
                result_valid    <= 1'b1;
                reference_force <= ref_out;
                index_rejected  <= rej_reg;
            end
            else if (result_valid && result_ready)
            begin
                result_valid <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= (in_range && measure_ok) ? S_P : S_DONE;
                    end
                end
                S_P:    state_reg <= S_KD;
                S_KD:   state_reg <= S_LO;
                S_LO:   state_reg <= S_HI;
                S_HI:   state_reg <= S_SUM;
                S_SUM:  state_reg <= S_INT;
                S_INT:  state_reg <= S_WIND;
                S_WIND: state_reg <= S_DONE;
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath steps
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_reg  <= contact[IDX_W-1:0];
                    rej_reg  <= !in_range;
                    zero_reg <= !(in_range && measure_ok);
                    dt_reg   <= time_step;
                    des_reg  <= des_in;
                    neg_reg  <= err_in[32];
                    mag_reg  <= err_in[32] ? err_neg[31:0] : err_in[31:0];
                end
            end
            S_P:
            begin
                iprev_reg <= st_rdata;
            end
            S_KD:
            begin
                // kp*|err| >> 16, signed back
                p_reg <= neg_reg ? -$signed({1'b0, prod[MUL_P_W-1:16]})
                                 : $signed({1'b0, prod[MUL_P_W-1:16]});
            end
            S_LO:
            begin
                kdhi_reg <= prod[47:24];
                pd_reg   <= 42'(p_reg) + 42'(des_reg);
            end
            S_HI:
            begin
                lo_reg  <= prod[MUL_P_W-1:24];
                pip_reg <= 43'(pd_reg) + 43'(iprev_reg);
            end
            S_SUM:
            begin
                // (|err|*kd_hi + (|err|*kd_lo >> 24)) >> 16
                q_reg <= 41'(({1'b0, prod} + 57'(lo_reg)) >> 16);
            end
            S_INT:
            begin
                inext_reg <= (dt_reg == '0) ? iprev_reg : inext_c[FORCE_W-1:0];
            end
            S_WIND:
            begin
                sel_reg <= wind ? pip_reg : raw;
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/pfra_mul.sv */
// ----------------------------------------------------------------------------
// pfra_mul
// Shared unsigned 32 x 24 multiplier with a registered product. The
// sequencer issues one product per cycle; it appears in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pfra_mul
    import pfra_pkg::*;
(
    input  wire logic               clk,
    input  wire logic [MUL_A_W-1:0] op_a,
    input  wire logic [MUL_B_W-1:0] op_b,
    output logic      [MUL_P_W-1:0] prod
);

    logic [MUL_P_W-1:0] prod_reg;

    // Multiply and register
    always_ff @(posedge clk)
    begin
        prod_reg <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

/* rtl/core/pfra_store.sv */
// ----------------------------------------------------------------------------
// pfra_store
// Per-contact integrator store: one signed Q16.16 entry per contact,
// cleared by reset, one write port and one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pfra_store
    import pfra_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int IDX_W = 3
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      wr_en,
    input  wire logic [IDX_W-1:0]          wr_idx,
    input  wire logic signed [FORCE_W-1:0] wr_data,
    input  wire logic [IDX_W-1:0]          rd_idx,
    output logic signed [FORCE_W-1:0]      rd_data
);

    logic signed [FORCE_W-1:0] entry_reg [DEPTH];

    // Clear on reset, write one entry per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                entry_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            entry_reg[wr_idx] <= wr_data;
        end
    end

    assign rd_data = entry_reg[rd_idx];

endmodule

`default_nettype wire

/* rtl/core/pfra_checker.sv */
// ----------------------------------------------------------------------------
// pfra_checker
// Port-level checks for the PI force reference generator, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pfra_checker
    import pfra_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      item_valid,
    input wire logic                      item_ready,
    input wire logic                      result_valid,
    input wire logic                      result_ready,
    input wire logic signed [FORCE_W-1:0] reference_force,
    input wire logic                      index_rejected
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(reference_force) && $stable(index_rejected))
    else $error("stalled result changed");

    // Rejected index always reads zero
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && index_rejected |-> reference_force == '0)
    else $error("rejected item gave nonzero force");

    // Go busy after taking an item
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
    else $error("ready stayed high after accept");

    // No result can appear the cycle right after acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !$rose(result_valid))
    else $error("result appeared too early");

endmodule

bind pi_force_reference_antiwindup pfra_checker u_pfra_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .reference_force (reference_force),
    .index_rejected  (index_rejected)
);

`default_nettype wire

/* tb/pi_force_reference_antiwindup_tb.sv */
// ----------------------------------------------------------------------------
// pi_force_reference_antiwindup_tb
// Self-checking bench for the per-contact PI force reference generator.
// Directed items cover index rejection, invalid measurements, field extremes,
// anti-windup, crossed bounds and a zero time step. Random runs mostly on one
// contact wind the integrators up and down under changing gains, limits and
// bounds. Every result is checked against a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------

module pi_force_reference_antiwindup_tb
    import pfra_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CONTACTS   = 8;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 236;
    localparam int SETTINGS_SPAN  = 59;
    localparam int DRAIN_SPAN     = 97;
    localparam int REPORT_CAP     = 50;

    // Register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_B = 3'd7;

    // One Newton in Q16.16
    localparam int NEWTON = 65536;

    typedef struct packed {
        logic [CONTACT_W-1:0] contact;
        logic                 measure_ok;
        logic [FORCE_W-1:0]   desired;
        logic [FORCE_W-1:0]   measured;
        logic [DT_W-1:0]      dt;
    } force_item_t;

    typedef struct packed {
        logic [FORCE_W-1:0] ref_force;
        logic               rejected;
    } force_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [FORCE_W-1:0]   cfg_data = '0;
    logic                 item_valid = 1'b0;
    logic                 item_ready;
    logic [CONTACT_W-1:0] contact = '0;
    logic                 measure_ok = 1'b0;
    logic [FORCE_W-1:0]   desired_force = '0;
    logic [FORCE_W-1:0]   measured_force = '0;
    logic [DT_W-1:0]      time_step = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    logic [FORCE_W-1:0]   reference_force;
    logic                 index_rejected;

    // Predictor state: register copy and integrator per contact
    pfra_cfg_t            model_cfg;
    logic [FORCE_W-1:0]   integ_store [NUM_CONTACTS];
    force_result_t        expected_refs [$];

    int sender_idle_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    always #1 clk = ~clk;

    pi_force_reference_antiwindup #(
        .NUM_CONTACTS(NUM_CONTACTS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .contact        (contact),
        .measure_ok     (measure_ok),
        .desired_force  (desired_force),
        .measured_force (measured_force),
        .time_step      (time_step),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .reference_force(reference_force),
        .index_rejected (index_rejected)
    );

    function automatic longint widen(input logic [FORCE_W-1:0] v);
        return {{32{v[FORCE_W-1]}}, v};
    endfunction

    // Compute the reference for one item and advance the integrator store
    function automatic force_result_t predict_reference(input force_item_t it);
        force_result_t res;
        longint        des, err, prop, step, i_prev, i_next, lim, lo, hi, total;
        logic [63:0]   mag, prop_mag;
        logic [127:0]  gain_w, dt_w, mag_w, prod;
        res = '0;
        if (it.contact >= NUM_CONTACTS) begin
            res.rejected = 1'b1;
            return res;
        end
        if (!it.measure_ok) begin
            integ_store[it.contact] = '0;
            return res;
        end
        des = widen(it.desired);
        if (des <= 0)
            des = widen(model_cfg.default_force);
        err = des - widen(it.measured);
        mag = (err < 0) ? -err : err;

        // proportional term, truncated toward zero
        prop_mag = ({40'd0, model_cfg.prop_gain} * mag) >> 16;
        prop = prop_mag;
        if (err < 0)
            prop = -prop;

        // integrator step ki*|err|*dt, exact product then truncated
        gain_w = 128'(model_cfg.integral_gain);
        dt_w = 128'(it.dt);
        mag_w = 128'(mag);
        prod = (gain_w * dt_w * mag_w) >> 40;
        step = prod[63:0];
        if (err < 0)
            step = -step;

        i_prev = widen(integ_store[it.contact]);
        i_next = i_prev;
        lim = longint'(model_cfg.integrator_limit);
        if (it.dt != '0) begin
            i_next = i_prev + step;
            if (i_next < -lim)
                i_next = -lim;
            if (i_next > lim)
                i_next = lim;
        end

        // drop the step when it pushes further into a saturated bound
        lo = widen(model_cfg.output_min);
        hi = widen(model_cfg.output_max);
        total = prop + i_next + des;
        if (!((total > hi && i_next > i_prev) || (total < lo && i_next < i_prev)))
            integ_store[it.contact] = i_next[31:0];

        // lower clamp first, then upper
        total = prop + widen(integ_store[it.contact]) + des;
        if (total < lo)
            total = lo;
        if (total > hi)
            total = hi;
        res.ref_force = total[31:0];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < REPORT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // Drive one item, hold it until accepted, then queue its prediction
    task automatic send_item(input force_item_t it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        contact <= it.contact;
        measure_ok <= it.measure_ok;
        desired_force <= it.desired;
        measured_force <= it.measured;
        time_step <= it.dt;
        do @(posedge clk); while (!item_ready);
        expected_refs.push_back(predict_reference(it));
    endtask

    // Hold the sender until every queued result has come back
    task automatic hold_until_drained();
        item_valid <= 1'b0;
        do @(posedge clk); while (expected_refs.size() != 0);
    endtask

    task automatic settle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [FORCE_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_PROP_GAIN:        model_cfg.prop_gain = data[GAIN_W-1:0];
            CFG_INTEGRAL_GAIN:    model_cfg.integral_gain = data[GAIN_W-1:0];
            CFG_INTEGRATOR_LIMIT: model_cfg.integrator_limit = data[LIMIT_W-1:0];
            CFG_OUTPUT_MIN:       model_cfg.output_min = data;
            CFG_OUTPUT_MAX:       model_cfg.output_max = data;
            CFG_DEFAULT_FORCE:    model_cfg.default_force = data;
            default:              ;
        endcase
        @(posedge clk);
    endtask

    // Write every register once while idle; junk goes into unused upper bits
    task automatic load_settings(input pfra_cfg_t s);
        logic [FORCE_W-1:0] junk;
        settle();
        junk = $urandom;
        write_register(CFG_PROP_GAIN, {junk[31:24], s.prop_gain});
        junk = $urandom;
        write_register(CFG_INTEGRAL_GAIN, {junk[31:24], s.integral_gain});
        junk = $urandom;
        write_register(CFG_INTEGRATOR_LIMIT, {junk[31], s.integrator_limit});
        write_register(CFG_OUTPUT_MIN, s.output_min);
        write_register(CFG_OUTPUT_MAX, s.output_max);
        write_register(CFG_DEFAULT_FORCE, s.default_force);
        write_register(SPARE_INDEX_A, $urandom);
        write_register(SPARE_INDEX_B, $urandom);
        cfg_we <= 1'b0;
    endtask

    function automatic force_item_t mk(input int c, input bit ok, input int des,
                                       input int meas, input int dt);
        force_item_t it;
        it.contact = CONTACT_W'(c);
        it.measure_ok = ok;
        it.desired = des;
        it.measured = meas;
        it.dt = DT_W'(dt);
        return it;
    endfunction

    function automatic pfra_cfg_t random_settings();
        pfra_cfg_t s;
        case ($urandom_range(5))
            0:       s.prop_gain = '0;
            1:       s.prop_gain = '1;
            2:       s.prop_gain = GAIN_W'($urandom);
            default: s.prop_gain = GAIN_W'($urandom_range(262144));
        endcase
        case ($urandom_range(5))
            0:       s.integral_gain = '0;
            1:       s.integral_gain = '1;
            2:       s.integral_gain = GAIN_W'($urandom);
            default: s.integral_gain = GAIN_W'($urandom_range(3276800));
        endcase
        case ($urandom_range(5))
            0:       s.integrator_limit = '0;
            1:       s.integrator_limit = '1;
            2:       s.integrator_limit = LIMIT_W'($urandom);
            default: s.integrator_limit = LIMIT_W'($urandom_range(60 * NEWTON));
        endcase
        case ($urandom_range(5))
            0:       s.output_min = OUTPUT_MIN_RST;
            1:       s.output_min = $urandom;
            default: s.output_min = -$urandom_range(80 * NEWTON);
        endcase
        case ($urandom_range(5))
            0:       s.output_max = OUTPUT_MAX_RST;
            1:       s.output_max = $urandom;
            default: s.output_max = $urandom_range(80 * NEWTON);
        endcase
        case ($urandom_range(6))
            0:       s.default_force = '0;
            1:       s.default_force = $urandom;
            2:       s.default_force = OUTPUT_MIN_RST;
            3:       s.default_force = OUTPUT_MAX_RST;
            default: s.default_force = $urandom_range(50 * NEWTON);
        endcase
        return s;
    endfunction

    // Mostly items on the focus contact with an error of one sign
    function automatic force_item_t random_item(input logic [CONTACT_W-1:0] focus,
                                                input bit lean);
        force_item_t        it;
        logic [FORCE_W-1:0] offset;
        case ($urandom_range(11))
            0:       it.contact = CONTACT_W'($urandom);
            1, 2:    it.contact = CONTACT_W'($urandom_range(NUM_CONTACTS - 1));
            default: it.contact = focus;
        endcase
        it.measure_ok = ($urandom_range(19) != 0);
        case ($urandom_range(9))
            0:       it.desired = $urandom;
            1:       it.desired = -$urandom_range(10 * NEWTON);
            default: it.desired = $urandom_range(100 * NEWTON, 1);
        endcase
        offset = $urandom_range(20 * NEWTON) - 2 * NEWTON;
        if (!lean)
            offset = -offset;
        case ($urandom_range(9))
            0:       it.measured = $urandom;
            default: it.measured = it.desired - offset;
        endcase
        case ($urandom_range(11))
            0:       it.dt = '0;
            1:       it.dt = DT_W'($urandom);
            default: it.dt = DT_W'($urandom_range(335544, 1));
        endcase
        return it;
    endfunction

    // Registers still at reset: output follows the desired force
    task automatic test_reset_settings();
        send_item(mk(0, 1'b1, 5 * NEWTON, 3 * NEWTON, 16777));
        send_item(mk(1, 1'b1, 0, 2 * NEWTON, 16777));
        send_item(mk(2, 1'b0, NEWTON, NEWTON, 100));
    endtask

    task automatic test_index_rejection();
        send_item(mk(NUM_CONTACTS, 1'b1, 5 * NEWTON, NEWTON, 16777));
        send_item(mk(15, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF));
        send_item(mk(15, 1'b0, 5 * NEWTON, NEWTON, 16777));
        send_item(mk(NUM_CONTACTS - 1, 1'b1, 5 * NEWTON, NEWTON, 16777));
    endtask

    // Largest gains and limit, widest errors in both directions
    task automatic test_field_extremes();
        pfra_cfg_t s;
        s.prop_gain = '1;
        s.integral_gain = '1;
        s.integrator_limit = '1;
        s.output_min = OUTPUT_MIN_RST;
        s.output_max = OUTPUT_MAX_RST;
        s.default_force = OUTPUT_MAX_RST;
        load_settings(s);
        send_item(mk(7, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF));
        send_item(mk(7, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 24'hFF_FFFF));
        send_item(mk(0, 1'b1, 1, 0, 1));
        send_item(mk(0, 1'b1, 0, 32'h7FFF_FFFF, 0));
        send_item(mk(3, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF));
        s.default_force = OUTPUT_MIN_RST;
        load_settings(s);
        send_item(mk(4, 1'b1, 0, 32'h7FFF_FFFF, 24'hFF_FFFF));
        send_item(mk(4, 1'b1, 32'hFFFF_FFFF, 32'h8000_0000, 24'h80_0000));
    endtask

    // Saturate both bounds, clear by invalid measurement, cross the bounds,
    // then shrink the limit and step with zero time so the value stays put
    task automatic test_antiwindup_bounds();
        pfra_cfg_t s;
        s.prop_gain = GAIN_W'(NEWTON);
        s.integral_gain = GAIN_W'(100 * NEWTON);
        s.integrator_limit = LIMIT_W'(10 * NEWTON);
        s.output_min = -15 * NEWTON;
        s.output_max = 15 * NEWTON;
        s.default_force = 2 * NEWTON;
        load_settings(s);
        send_item(mk(1, 1'b1, 5 * NEWTON, NEWTON, 167772));
        send_item(mk(1, 1'b1, 5 * NEWTON, NEWTON, 167772));
        send_item(mk(1, 1'b1, 5 * NEWTON, 9 * NEWTON, 167772));
        send_item(mk(1, 1'b1, NEWTON, 30 * NEWTON, 167772));
        send_item(mk(1, 1'b1, -NEWTON, 30 * NEWTON, 0));
        send_item(mk(1, 1'b0, 5 * NEWTON, NEWTON, 167772));
        send_item(mk(3, 1'b1, 5 * NEWTON, NEWTON, 167772));
        s.output_min = 10 * NEWTON;
        s.output_max = -10 * NEWTON;
        load_settings(s);
        send_item(mk(2, 1'b1, 5 * NEWTON, NEWTON, 167772));
        send_item(mk(NUM_CONTACTS - 1, 1'b1, 50 * NEWTON, -50 * NEWTON, 0));
        s.integrator_limit = LIMIT_W'(NEWTON);
        s.output_min = OUTPUT_MIN_RST;
        s.output_max = OUTPUT_MAX_RST;
        load_settings(s);
        send_item(mk(3, 1'b1, 5 * NEWTON, NEWTON, 0));
    endtask

    // Runs mostly on one contact under each idle and stall mix and changing settings
    task automatic test_random_traffic();
        int                   idle_mix [4] = '{0, 73, 0, 26};
        int                   stall_mix [4] = '{0, 0, 73, 26};
        int                   run_left;
        logic [CONTACT_W-1:0] focus;
        bit                   lean;
        run_left = 0;
        focus = '0;
        lean = 1'b1;
        for (int phase = 0; phase < 4; phase++)
        begin
            sender_idle_pct = idle_mix[phase];
            stall_pct = stall_mix[phase];
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % SETTINGS_SPAN == 0)
                    load_settings(random_settings());
                else if (n % DRAIN_SPAN == DRAIN_SPAN / 2)
                    hold_until_drained();
                if (run_left == 0)
                begin
                    focus = CONTACT_W'($urandom_range(NUM_CONTACTS - 1));
                    lean = 1'($urandom_range(1));
                    run_left = $urandom_range(30, 5);
                end
                send_item(random_item(focus, lean));
                run_left--;
            end
        end
    endtask

    // Stall the receiver at random and check each result in order
    always @(posedge clk)
    begin : result_check
        force_result_t want;
        result_ready <= ($urandom_range(99) >= stall_pct);
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_refs.size() == 0)
                report_mismatch($sformatf("unexpected result ref=%0d rej=%0b",
                                          $signed(reference_force), index_rejected));
            else
            begin
                want = expected_refs.pop_front();
                if (reference_force !== want.ref_force)
                    report_mismatch($sformatf("reference_force got %0d want %0d",
                                              $signed(reference_force),
                                              $signed(want.ref_force)));
                if (index_rejected !== want.rejected)
                    report_mismatch($sformatf("index_rejected got %0b want %0b",
                                              index_rejected, want.rejected));
            end
        end
    end

    // End the run if nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        model_cfg.prop_gain = '0;
        model_cfg.integral_gain = '0;
        model_cfg.integrator_limit = '0;
        model_cfg.output_min = OUTPUT_MIN_RST;
        model_cfg.output_max = OUTPUT_MAX_RST;
        model_cfg.default_force = '0;
        foreach (integ_store[i])
            integ_store[i] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_settings();
        test_index_rejection();
        test_field_extremes();
        test_antiwindup_bounds();
        test_random_traffic();
        settle();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
